// ===== rtl/core/pointer_driven_view_rotation_macros.svh =====
// Assertion macros for the pointer driven view rotation block.
// Included by the RTL files that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef POINTER_DRIVEN_VIEW_ROTATION_MACROS_SVH
`define POINTER_DRIVEN_VIEW_ROTATION_MACROS_SVH

`ifndef SYNTHESIS

// Property that holds at every clock edge outside reset.
`define PDVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define PDVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PDVR_ASSERT(label, prop, msg)
`define PDVR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/pdvr_pkg.sv =====
// Package for the pointer driven view rotation block: widths, register indexes and the
// request/result structs of the CORDIC unit. No dependencies.
`default_nettype none

package pdvr_pkg;

  localparam int PointerBits = 12;
  localparam int VecFracBits = 16;
  localparam int CordicSteps = 16;

  localparam int VecBits  = VecFracBits + 2;
  localparam int AngBits  = 17;               // clamped angle, signed Q0.16
  localparam int CordicW  = 34;               // signed Q3.30 with headroom
  localparam int InDataW  = ((PointerBits + 4 * VecBits + 7) / 8) * 8;
  localparam int OutDataW = ((4 * VecBits + 7) / 8) * 8;

  localparam logic [1:0] RegDeadZone    = 2'd0;
  localparam logic [1:0] RegSensitivity = 2'd1;
  localparam logic [1:0] RegMaxAngle    = 2'd2;

  typedef struct packed {
    logic                      start;
    logic signed [AngBits-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [CordicW-1:0] cos_val;
    logic signed [CordicW-1:0] sin_val;
  } cordic_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/pdvr_cordic.sv =====
// Iterative CORDIC in rotation mode, one micro-rotation per cycle.
// Depends on pdvr_pkg for widths and the request/result structs.
`default_nettype none

module pdvr_cordic (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pdvr_pkg::cordic_req_t req_i,
  output pdvr_pkg::cordic_res_t     res_o
);
  import pdvr_pkg::*;

  localparam int IterBits = (CordicSteps > 1) ? $clog2(CordicSteps) : 1;
  localparam logic [IterBits-1:0] LastIter = IterBits'(CordicSteps - 1);
  localparam logic signed [CordicW-1:0] GainQ30 = CordicW'(32'sh26DD3B6A);

  function automatic logic signed [CordicW-1:0] atan_q30(input logic [IterBits-1:0] i);
    logic [CordicW-1:0] one;
    one = CordicW'(1);
    case (int'(i))
      0: atan_q30 = CordicW'(32'h3243F6A9);
      1: atan_q30 = CordicW'(32'h1DAC6705);
      2: atan_q30 = CordicW'(32'h0FADBAFD);
      3: atan_q30 = CordicW'(32'h07F56EA7);
      4: atan_q30 = CordicW'(32'h03FEAB77);
      5: atan_q30 = CordicW'(32'h01FFD55C);
      6: atan_q30 = CordicW'(32'h00FFFAAB);
      7: atan_q30 = CordicW'(32'h007FFF55);
      8: atan_q30 = CordicW'(32'h003FFFEB);
      9: atan_q30 = CordicW'(32'h001FFFFD);
      default: atan_q30 = one << (30 - int'(i));
    endcase
  endfunction

  logic signed [CordicW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [CordicW-1:0] dx, dy, at;
  logic [IterBits-1:0]       iter_q, iter_d;
  logic                      busy_q, busy_d, done_q, done_d;

  assign dx = x_q >>> iter_q;
  assign dy = y_q >>> iter_q;
  assign at = atan_q30(iter_q);

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    iter_d = iter_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      x_d    = GainQ30;
      y_d    = '0;
      // Q0.16 angle into Q3.30
      z_d    = {{(CordicW - AngBits){req_i.angle[AngBits-1]}}, req_i.angle} <<< 14;
      iter_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[CordicW-1]) begin
        x_d = x_q - dy;
        y_d = y_q + dx;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dy;
        y_d = y_q - dx;
        z_d = z_q + at;
      end
      if (iter_q == LastIter) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        iter_d = iter_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign res_o.done    = done_q;
  assign res_o.cos_val = x_q;
  assign res_o.sin_val = y_q;

endmodule

`default_nettype wire

// ===== rtl/core/pointer_driven_view_rotation.sv =====
// Pointer driven view rotation: a rotating move passes through angle multiply and clamp,
// 16 CORDIC steps, the shared 18x34 multiplier, update and output; a load, a first move
// or a move inside the dead zone goes straight to the output step.
// One item at a time: a new transaction can be taken once the result is posted, and the
// block waits to post it while the output stays full.
// Reset (async, active low): vectors zero, no reference, registers at their defaults.
`default_nettype none

module pointer_driven_view_rotation (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: pointer_x, load_dir_x, load_dir_y, load_plane_x, load_plane_y, zero pad
  input  wire logic [pdvr_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: command
  input  wire logic                          s_axis_tuser,
  // output stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: out_dir_x, out_dir_y, out_plane_x, out_plane_y
  output logic [pdvr_pkg::OutDataW-1:0]      m_axis_tdata,
  // tuser: rotated
  output logic                               m_axis_tuser
);
  import pdvr_pkg::*;

  `include "pointer_driven_view_rotation_macros.svh"

  localparam int DeltaW  = PointerBits + 1;
  localparam int AngProdW = DeltaW + AngBits;
  localparam int ProdW   = VecBits + CordicW;
  localparam int AccW    = ProdW + 1;
  localparam logic [3:0] MulLast = 4'd8;
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< 29;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StAng  = 3'd1;
  localparam logic [2:0] StCord = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StUpd  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  function automatic logic signed [VecBits-1:0] sat_vec(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] sh, hi, lo;
    sh = v >>> 30;
    hi = {{(AccW - VecBits + 1){1'b0}}, {(VecBits - 1){1'b1}}};
    lo = ~hi;
    if (sh > hi) sat_vec = hi[VecBits-1:0];
    else if (sh < lo) sat_vec = lo[VecBits-1:0];
    else sat_vec = sh[VecBits-1:0];
  endfunction

  // configuration
  logic [3:0]  dead_zone_q;
  logic [15:0] sens_q, max_angle_q;

  // block state
  logic [2:0]               state_q;
  logic [PointerBits-1:0]   ref_x_q, px_q;
  logic                     ref_valid_q;
  logic signed [VecBits-1:0] dir_x_q, dir_y_q, pln_x_q, pln_y_q;
  logic signed [VecBits-1:0] nv_q [4];
  logic signed [DeltaW-1:0] delta_q;
  logic                     rot_q;
  logic [3:0]               mul_cnt_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q;

  // output register
  logic                     out_valid_q, out_rot_q;
  logic [4*VecBits-1:0]     out_data_q;

  // input fields
  logic [PointerBits-1:0]    in_px;
  logic signed [VecBits-1:0] in_dx, in_dy, in_pxv, in_pyv;
  logic                      in_acc, out_free;
  logic signed [DeltaW-1:0]  delta;
  logic [DeltaW-1:0]         mag;

  assign in_px  = s_axis_tdata[PointerBits-1:0];
  assign in_dx  = s_axis_tdata[PointerBits +: VecBits];
  assign in_dy  = s_axis_tdata[PointerBits + VecBits +: VecBits];
  assign in_pxv = s_axis_tdata[PointerBits + 2 * VecBits +: VecBits];
  assign in_pyv = s_axis_tdata[PointerBits + 3 * VecBits +: VecBits];

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign delta = $signed({1'b0, in_px}) - $signed({1'b0, ref_x_q});
  assign mag   = delta[DeltaW-1] ? DeltaW'(-delta) : DeltaW'(delta);

  // angle = delta * sensitivity, clamped to +/- max_angle
  logic signed [AngProdW-1:0] ang_prod, ang_lim, ang_clamped;
  assign ang_prod = delta_q * $signed({1'b0, sens_q});
  assign ang_lim  = AngProdW'($signed({1'b0, max_angle_q}));
  always_comb begin
    if (ang_prod > ang_lim) ang_clamped = ang_lim;
    else if (ang_prod < -ang_lim) ang_clamped = -ang_lim;
    else ang_clamped = ang_prod;
  end

  cordic_req_t cord_req;
  cordic_res_t cord_res;
  assign cord_req.start = (state_q == StAng);
  assign cord_req.angle = ang_clamped[AngBits-1:0];

  pdvr_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cord_req),
    .res_o  (cord_res)
  );

  // shared multiplier operands: dx*c, dy*-s, dx*s, dy*c, then the same for the plane
  logic signed [VecBits-1:0] mul_a;
  logic signed [CordicW-1:0] mul_b;
  logic [2:0]                mul_k;
  logic signed [AccW-1:0]    mac_sum;
  always_comb begin
    if (mul_cnt_q[2]) mul_a = mul_cnt_q[0] ? pln_y_q : pln_x_q;
    else mul_a = mul_cnt_q[0] ? dir_y_q : dir_x_q;
    case (mul_cnt_q[1:0])
      2'd0:    mul_b = cord_res.cos_val;
      2'd1:    mul_b = -cord_res.sin_val;
      2'd2:    mul_b = cord_res.sin_val;
      default: mul_b = cord_res.cos_val;
    endcase
  end
  assign mul_k   = 3'(mul_cnt_q - 4'd1);
  assign mac_sum = acc_q + AccW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= 4'd2;
      sens_q      <= 16'd197;
      max_angle_q <= 16'd6554;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegDeadZone:    dead_zone_q <= cfg_data_i[3:0];
        RegSensitivity: sens_q      <= cfg_data_i;
        RegMaxAngle:    max_angle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ref_valid_q <= 1'b0;
      ref_x_q     <= '0;
      dir_x_q     <= '0;
      dir_y_q     <= '0;
      pln_x_q     <= '0;
      pln_y_q     <= '0;
      rot_q       <= 1'b0;
      mul_cnt_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            rot_q <= 1'b0;
            if (s_axis_tuser) begin
              dir_x_q <= in_dx;
              dir_y_q <= in_dy;
              pln_x_q <= in_pxv;
              pln_y_q <= in_pyv;
              state_q <= StFin;
            end else if (!ref_valid_q) begin
              ref_x_q     <= in_px;
              ref_valid_q <= 1'b1;
              state_q     <= StFin;
            end else if (mag >= DeltaW'(dead_zone_q)) begin
              state_q <= StAng;
            end else begin
              state_q <= StFin;
            end
          end
        end
        StAng: state_q <= StCord;
        StCord: begin
          mul_cnt_q <= '0;
          if (cord_res.done) state_q <= StMul;
        end
        StMul: begin
          mul_cnt_q <= mul_cnt_q + 4'd1;
          if (mul_cnt_q == MulLast) state_q <= StUpd;
        end
        StUpd: begin
          dir_x_q <= nv_q[0];
          dir_y_q <= nv_q[1];
          pln_x_q <= nv_q[2];
          pln_y_q <= nv_q[3];
          ref_x_q <= px_q;
          rot_q   <= 1'b1;
          state_q <= StFin;
        end
        StFin: begin
          if (out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // post the result from StFin, drop it once the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StFin && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      delta_q <= delta;
      px_q    <= in_px;
    end
    prod_q <= mul_a * mul_b;
    if (state_q == StMul && mul_cnt_q != '0) begin
      // even term opens a sum with the rounding half, odd term closes it
      if (!mul_k[0]) acc_q <= AccW'(prod_q) + RoundHalf;
      else nv_q[mul_k[2:1]] <= sat_vec(mac_sum);
    end
    if (state_q == StFin && out_free) begin
      out_data_q <= {pln_y_q, pln_x_q, dir_y_q, dir_x_q};
      out_rot_q  <= rot_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_data_q);
  assign m_axis_tuser  = out_rot_q;

  `PDVR_ASSERT(a_cordic_done_in_cord, cord_res.done |-> state_q == StCord, "stray CORDIC done")
  `PDVR_ASSERT(a_mul_cnt_bound, state_q == StMul |-> mul_cnt_q <= MulLast, "multiply overrun")
  `PDVR_ASSERT(a_rot_needs_ref, (out_valid_q && out_rot_q) |-> ref_valid_q, "no reference")
  `PDVR_ASSERT_NEXT(a_fin_to_idle, state_q == StFin && out_free, state_q == StIdle && out_valid_q, "not posted")

endmodule

`default_nettype wire
